// ===== rtl/pcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared sizes, codes and types of the percentile contrast stretch block.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // Histogram geometry and counter width
  localparam int BINS       = 1024;
  localparam int COUNT_BITS = 20;
  localparam int IDX_BITS   = $clog2(BINS + 1);
  localparam int SUM_BITS   = COUNT_BITS + IDX_BITS;

  // Field widths
  localparam int VALUE_BITS   = 13;
  localparam int VALUE_ONE    = 4096;
  localparam int VALUE_SHIFT  = 12;
  localparam int OPCODE_BITS  = 2;
  localparam int CUT_BITS     = 13;
  localparam int STRETCH_BITS = 16;
  localparam int PCT_BITS     = 7;
  localparam int PCT_FULL     = 100;

  // Stretch arithmetic: v*BINS and cut*4096 share one width
  localparam int PROD_BITS    = $clog2(VALUE_ONE * BINS + 1);
  localparam int DIVD_BITS    = PROD_BITS + 1;
  localparam int DIVR_BITS    = IDX_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(DIVD_BITS + 1);

  // Percent products and their division by a hundred
  localparam int PCT_PROD_BITS = COUNT_BITS + PCT_BITS;
  localparam logic [PCT_PROD_BITS-1:0] PCT_RECIP =
    PCT_PROD_BITS'((64'd1 << PCT_PROD_BITS) / 64'd100);

  // Saturation bounds of the stretched word
  localparam int STR_MAX = 32767;
  localparam int STR_MIN = -32768;

  // Opcodes; code 3 carries no meaning
  localparam logic [OPCODE_BITS-1:0] OP_LOAD    = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_FINISH  = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_STRETCH = 2'd2;

  // Result kinds
  localparam logic KIND_CUT     = 1'b0;
  localparam logic KIND_STRETCH = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_PCT  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_PCT = 1'd1;

  localparam logic [PCT_BITS-1:0] LOW_PCT_RESET  = 7'd5;
  localparam logic [PCT_BITS-1:0] HIGH_PCT_RESET = 7'd95;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    logic [VALUE_BITS-1:0]  value;
  } item_t;

  typedef struct packed {
    logic                           kind;
    logic [CUT_BITS-1:0]            low_cut;
    logic [CUT_BITS-1:0]            high_cut;
    logic signed [STRETCH_BITS-1:0] stretched;
    logic                           clipped;
  } result_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic load_rd;
    logic load_wr;
    logic clr_wr;
    logic idx_step;
    logic fin_mul;
    logic fin_recip;
    logic fin_corr;
    logic scan_rd;
    logic str_prep;
    logic div_start;
    logic report_fin;
    logic report_str;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic idx_last;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/percentile_contrast_stretch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// percentile_contrast_stretch
// Histogram percentile contrast stretch of Q1.12 intensities.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------
//   command  | start, busy                | item (opcode, value)
//   result   | done (one-cycle strobe)    | result (kind, cuts, stretched)
//   config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// A load word reads its histogram bin, then writes the count plus one back.
// A finish word does the threshold math, then one memory read and clear per
// bin over all BINS + 1 bins, then reports the cuts. A stretch word prepares
// the divider operands and waits on the one-bit-per-cycle divider.
// After reset the block sweeps all BINS + 1 histogram bins to zero with busy
// high. Results cannot be stalled; config writes are always taken.
// ----------------------------------------------------------------------------
module percentile_contrast_stretch (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire pcs_pkg::item_t                   item,
  output logic                                  done,
  output pcs_pkg::result_t                      result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pcs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [pcs_pkg::PCT_BITS-1:0]     cfg_data
);
  import pcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  pcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pcs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result),
    .done      (done)
  );

  // A meaningful command word always leaves the block busy next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.opcode == OP_LOAD || item.opcode == OP_FINISH ||
                        item.opcode == OP_STRETCH)) |=> busy)
    else $error("block idle after accepting a command word");

  // A result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // Reported cuts stay inside the histogram
  a_cut_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == KIND_CUT) |->
      (result.low_cut <= CUT_BITS'(BINS) && result.high_cut <= CUT_BITS'(BINS)))
    else $error("cut outside histogram range");

  // A clipped stretch word sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (done && result.clipped) |->
      (result.stretched == STRETCH_BITS'(STR_MAX) ||
       result.stretched == STRETCH_BITS'(STR_MIN)))
    else $error("clipped flag without saturated value");

endmodule
`default_nettype wire

// ===== rtl/pcs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: reset clearing pass, load, finish scan and stretch steps.
// ----------------------------------------------------------------------------
module pcs_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [pcs_pkg::OPCODE_BITS-1:0] opcode,
  input  wire pcs_pkg::status_t                status,
  output pcs_pkg::cmd_t                        cmd,
  output logic                                 busy
);
  import pcs_pkg::*;

  typedef enum logic [3:0] {
    CLEAR, IDLE, LOAD_WR, FIN_MUL, FIN_RECIP, FIN_CORR,
    SCAN, SCAN_DRAIN, FIN_REPORT, STR_PREP, STR_GO, STR_WAIT
  } state_t;

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      CLEAR: begin
        cmd.clr_wr   = 1'b1;
        cmd.idx_step = 1'b1;
        if (status.idx_last) begin
          state_next = IDLE;
        end
      end
      IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (opcode)
            OP_LOAD: begin
              cmd.load_rd = 1'b1;
              state_next  = LOAD_WR;
            end
            OP_FINISH:  state_next = FIN_MUL;
            OP_STRETCH: state_next = STR_PREP;
            default:    state_next = IDLE;
          endcase
        end
      end
      LOAD_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = IDLE;
      end
      FIN_MUL: begin
        cmd.fin_mul = 1'b1;
        state_next  = FIN_RECIP;
      end
      FIN_RECIP: begin
        cmd.fin_recip = 1'b1;
        state_next    = FIN_CORR;
      end
      FIN_CORR: begin
        cmd.fin_corr = 1'b1;
        state_next   = SCAN;
      end
      SCAN: begin
        cmd.scan_rd  = 1'b1;
        cmd.idx_step = 1'b1;
        if (status.idx_last) begin
          state_next = SCAN_DRAIN;
        end
      end
      SCAN_DRAIN: state_next = FIN_REPORT;
      FIN_REPORT: begin
        cmd.report_fin = 1'b1;
        state_next     = IDLE;
      end
      STR_PREP: begin
        cmd.str_prep = 1'b1;
        state_next   = STR_GO;
      end
      STR_GO: begin
        cmd.div_start = 1'b1;
        state_next    = STR_WAIT;
      end
      STR_WAIT: begin
        if (status.div_done) begin
          cmd.report_str = 1'b1;
          state_next     = IDLE;
        end
      end
      default: state_next = CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pcs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_div
// Restoring divider, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module pcs_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pcs_pkg::DIVD_BITS-1:0] dividend,
  input  wire logic [pcs_pkg::DIVR_BITS-1:0] divisor,
  output logic [pcs_pkg::DIVD_BITS-1:0]      quotient,
  output logic                               done
);
  import pcs_pkg::*;

  logic                    running;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIVR_BITS-1:0]    dvsr;
  logic [DIVR_BITS-1:0]    rem;
  logic [DIVR_BITS-1:0]    rem_next;
  logic [DIVR_BITS:0]      rem_shift;
  logic [DIVR_BITS:0]      trial;
  logic                    q_bit;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    rem_shift = {rem, quotient[DIVD_BITS-1]};
    trial     = rem_shift - {1'b0, dvsr};
    q_bit     = (rem_shift >= {1'b0, dvsr});
    rem_next  = q_bit ? trial[DIVR_BITS-1:0] : rem_shift[DIVR_BITS-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_BITS'(DIVD_BITS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Operands; the quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr     <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (running) begin
      rem      <= rem_next;
      quotient <= {quotient[DIVD_BITS-2:0], q_bit};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pcs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_datapath
// Histogram memory, percentile thresholds, bin scan, stretch and result word.
// ----------------------------------------------------------------------------
module pcs_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pcs_pkg::cmd_t                    cmd,
  input  wire pcs_pkg::item_t                   item,
  input  wire logic                             cfg_we,
  input  wire logic [pcs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [pcs_pkg::PCT_BITS-1:0]     cfg_data,
  output pcs_pkg::status_t                      status,
  output pcs_pkg::result_t                      result,
  output logic                                  done
);
  import pcs_pkg::*;

  localparam logic [IDX_BITS-1:0]   LAST_BIN  = IDX_BITS'(BINS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration
  logic [PCT_BITS-1:0] low_pct, high_pct;

  // Histogram memory
  logic [COUNT_BITS-1:0] hist_mem [BINS+1];
  logic [COUNT_BITS-1:0] mem_rdata;
  logic                  mem_we, mem_re;
  logic [IDX_BITS-1:0]   mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  // Load path
  logic [VALUE_BITS-1:0] v_in;
  logic [PROD_BITS-1:0]  bin_prod;
  logic [IDX_BITS-1:0]   bin_in;
  logic [IDX_BITS-1:0]   bin_reg;
  logic [VALUE_BITS-1:0] v_reg;
  logic [COUNT_BITS-1:0] value_count;
  logic [COUNT_BITS-1:0] bin_inc;

  // Index walker
  logic [IDX_BITS-1:0] idx;

  // Thresholds
  logic [PCT_BITS-1:0]        low_eff, high_eff;
  logic [PCT_PROD_BITS-1:0]   x_lo, x_hi;
  logic [COUNT_BITS-1:0]      q_lo, q_hi;
  logic [2*PCT_PROD_BITS-1:0] recip_lo, recip_hi;
  logic [PCT_PROD_BITS-1:0]   rem_lo, rem_hi;
  logic [COUNT_BITS-1:0]      thr_lo, thr_hi;

  // Scan
  logic                proc_vld;
  logic [IDX_BITS-1:0] proc_idx;
  logic [SUM_BITS-1:0] sum, sum_next;
  logic                stopped;
  logic [IDX_BITS-1:0] scan_c, scan_d;
  logic [IDX_BITS-1:0] cut_low, cut_high;

  // Stretch
  logic [PROD_BITS-1:0] v_prod, c_prod, mag;
  logic [IDX_BITS-1:0]  den;
  logic                 neg, neg_reg;
  logic [DIVD_BITS-1:0] dividend, quotient;
  logic [DIVR_BITS-1:0] divisor;
  logic                 div_done;
  logic                 str_clip;
  logic [STRETCH_BITS-1:0] str_word;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_pct  <= LOW_PCT_RESET;
      high_pct <= HIGH_PCT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW_PCT:  low_pct  <= cfg_data;
        CFG_HIGH_PCT: high_pct <= cfg_data;
        default: ;
      endcase
    end
  end

  // Quantize the incoming value to a bin
  always_comb begin
    v_in     = (item.value > VALUE_BITS'(VALUE_ONE)) ? VALUE_BITS'(VALUE_ONE) : item.value;
    bin_prod = PROD_BITS'(v_in) * PROD_BITS'(BINS) + PROD_BITS'(VALUE_ONE / 2);
    bin_in   = IDX_BITS'(bin_prod >> VALUE_SHIFT);
    bin_inc  = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + 1'b1;
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v_reg   <= v_in;
      bin_reg <= bin_in;
    end
  end

  // Select memory port enables, addresses and write data
  always_comb begin
    mem_we    = cmd.clr_wr | cmd.scan_rd | cmd.load_wr;
    mem_waddr = cmd.load_wr ? bin_reg : idx;
    mem_wdata = cmd.load_wr ? bin_inc : '0;
    mem_re    = cmd.load_rd | cmd.scan_rd;
    mem_raddr = cmd.load_rd ? bin_in : idx;
  end

  // Histogram memory, read before write at the same address
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= hist_mem[mem_raddr];
    end
  end

  // Walk the bins for clearing and scanning, wrap after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_step) begin
      idx <= (idx == LAST_BIN) ? '0 : idx + 1'b1;
    end
  end

  assign status.idx_last = (idx == LAST_BIN);
  assign status.div_done = div_done;

  // Count loaded values, drop the count once reported
  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
    end else if (cmd.load_wr && value_count != COUNT_MAX) begin
      value_count <= value_count + 1'b1;
    end else if (cmd.report_fin) begin
      value_count <= '0;
    end
  end

  // Thresholds: n*pct, then divide by a hundred with reciprocal and correction
  always_comb begin
    low_eff  = (low_pct > PCT_BITS'(PCT_FULL)) ? PCT_BITS'(PCT_FULL) : low_pct;
    high_eff = (high_pct > PCT_BITS'(PCT_FULL)) ? PCT_BITS'(PCT_FULL) : high_pct;
    rem_lo   = x_lo - PCT_PROD_BITS'(q_lo) * PCT_PROD_BITS'(PCT_FULL);
    rem_hi   = x_hi - PCT_PROD_BITS'(q_hi) * PCT_PROD_BITS'(PCT_FULL);
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_mul) begin
      x_lo <= PCT_PROD_BITS'(value_count) * PCT_PROD_BITS'(low_eff);
      x_hi <= PCT_PROD_BITS'(value_count) * PCT_PROD_BITS'(high_eff);
    end
    if (cmd.fin_recip) begin
      recip_lo <= (2*PCT_PROD_BITS)'(x_lo) * (2*PCT_PROD_BITS)'(PCT_RECIP);
      recip_hi <= (2*PCT_PROD_BITS)'(x_hi) * (2*PCT_PROD_BITS)'(PCT_RECIP);
    end
    if (cmd.fin_corr) begin
      thr_lo <= (rem_lo >= PCT_PROD_BITS'(PCT_FULL)) ? q_lo + 1'b1 : q_lo;
      thr_hi <= (rem_hi >= PCT_PROD_BITS'(PCT_FULL)) ? q_hi + 1'b1 : q_hi;
    end
  end

  assign q_lo = recip_lo[PCT_PROD_BITS+COUNT_BITS-1:PCT_PROD_BITS];
  assign q_hi = recip_hi[PCT_PROD_BITS+COUNT_BITS-1:PCT_PROD_BITS];

  // Scan: one bin per cycle behind the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld <= 1'b0;
    end else begin
      proc_vld <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= idx;
  end

  assign sum_next = sum + SUM_BITS'(mem_rdata);

  always_ff @(posedge clk) begin
    if (cmd.fin_mul) begin
      sum     <= '0;
      stopped <= 1'b0;
      scan_c  <= '0;
      scan_d  <= LAST_BIN;
    end else if (proc_vld && !stopped) begin
      sum <= sum_next;
      if (sum_next < SUM_BITS'(thr_lo)) begin
        scan_c <= (proc_idx == '0) ? '0 : proc_idx - 1'b1;
      end
      if (sum_next > SUM_BITS'(thr_hi)) begin
        scan_d  <= (proc_idx == LAST_BIN) ? LAST_BIN : proc_idx + 1'b1;
        stopped <= 1'b1;
      end
    end
  end

  // Keep the cuts for later stretch words
  always_ff @(posedge clk) begin
    if (rst) begin
      cut_low  <= '0;
      cut_high <= LAST_BIN;
    end else if (cmd.report_fin) begin
      cut_low  <= scan_c;
      cut_high <= scan_d;
    end
  end

  // Stretch operands: |v*BINS - 4096*c| and the rounding offset
  always_comb begin
    v_prod   = PROD_BITS'(v_reg) * PROD_BITS'(BINS);
    c_prod   = PROD_BITS'(cut_low) << VALUE_SHIFT;
    neg      = (v_prod < c_prod);
    mag      = neg ? c_prod - v_prod : v_prod - c_prod;
    den      = (cut_high > cut_low) ? cut_high - cut_low : IDX_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.str_prep) begin
      neg_reg  <= neg;
      dividend <= {mag, 1'b0} + DIVD_BITS'(den);
      divisor  <= {den, 1'b0};
    end
  end

  pcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  // Apply sign and saturate
  always_comb begin
    if (neg_reg) begin
      str_clip = (quotient > DIVD_BITS'(-STR_MIN));
      str_word = str_clip ? STRETCH_BITS'(STR_MIN) : STRETCH_BITS'(-quotient);
    end else begin
      str_clip = (quotient > DIVD_BITS'(STR_MAX));
      str_word = str_clip ? STRETCH_BITS'(STR_MAX) : quotient[STRETCH_BITS-1:0];
    end
  end

  // Result word and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report_fin | cmd.report_str;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report_fin) begin
      result.kind      <= KIND_CUT;
      result.low_cut   <= CUT_BITS'(scan_c);
      result.high_cut  <= CUT_BITS'(scan_d);
      result.stretched <= '0;
      result.clipped   <= 1'b0;
    end else if (cmd.report_str) begin
      result.kind      <= KIND_STRETCH;
      result.low_cut   <= '0;
      result.high_cut  <= '0;
      result.stretched <= str_word;
      result.clipped   <= str_clip;
    end
  end

endmodule
`default_nettype wire
